FILE: hdl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared constants, word types and sequencer-to-memory port bundles for the
// maximum clique search block.
// ----------------------------------------------------------------------------
package mcs_pkg;

    // Graph size limit and derived widths
    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Fixed field widths of the external words
    localparam int ROW_INDEX_W = 6;
    localparam int ROW_BITS_W  = 64;
    localparam int SIZE_W      = 7;
    localparam int VCOUNT_W    = 7;

    // Reset value of the vertex count register
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);

    // Command codes
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    // Input word
    typedef struct packed {
        t_cmd                   command;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_BITS_W-1:0]  row_bits;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [SIZE_W-1:0]     max_clique_size;
        logic [ROW_BITS_W-1:0] clique_members;
    } t_out_word;

    // Path stack access from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_stk_port;

endpackage

FILE: hdl/mcs_adj_mem.sv
// ----------------------------------------------------------------------------
// mcs_adj_mem
// Adjacency row memory: one write port for row loads, one registered read
// port for the search sequencer.
// ----------------------------------------------------------------------------
module mcs_adj_mem (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [mcs_pkg::IDX_W-1:0]           i_waddr,
    input  logic [mcs_pkg::MAX_VERTICES-1:0]    i_wdata,
    input  logic [mcs_pkg::IDX_W-1:0]           i_raddr,
    output logic [mcs_pkg::MAX_VERTICES-1:0]    o_rdata
);
    import mcs_pkg::*;

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mcs_stack_mem.sv
// ----------------------------------------------------------------------------
// mcs_stack_mem
// Path stack: vertex on each level of the current clique, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module mcs_stack_mem (
    input  logic                        i_clk,
    input  mcs_pkg::t_stk_port          i_port,
    output logic [mcs_pkg::IDX_W-1:0]   o_rdata
);
    import mcs_pkg::*;

    logic [IDX_W-1:0] mem [MAX_VERTICES];
    logic [IDX_W-1:0] r_rdata;

    // Push writes
    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            mem[i_port.waddr] <= i_port.wdata;
        end
    end

    // Registered read for the level below the top after a pop
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_port.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mcs_ext_unit.sv
// ----------------------------------------------------------------------------
// mcs_ext_unit
// Shared extension test: a candidate fits when its adjacency row covers
// every current member of the clique.
// ----------------------------------------------------------------------------
module mcs_ext_unit (
    input  logic [mcs_pkg::MAX_VERTICES-1:0] i_row,
    input  logic [mcs_pkg::MAX_VERTICES-1:0] i_members,
    output logic                             o_fits
);
    import mcs_pkg::*;

    // Subset check: row must hold every member bit
    assign o_fits = ((i_row & i_members) == i_members);

endmodule

FILE: hdl/mcs_seq.sv
// ----------------------------------------------------------------------------
// mcs_seq
// Backtracking sequencer: walks candidates one at a time through the shared
// extension test, pushes and pops the path stack, tracks the best clique.
// ----------------------------------------------------------------------------
module mcs_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic [mcs_pkg::VCOUNT_W-1:0]        i_vertex_count,
    output logic [mcs_pkg::IDX_W-1:0]           o_adj_raddr,
    input  logic [mcs_pkg::MAX_VERTICES-1:0]    i_adj_rdata,
    output mcs_pkg::t_stk_port                  o_stk,
    input  logic [mcs_pkg::IDX_W-1:0]           i_stk_rdata,
    output logic [mcs_pkg::MAX_VERTICES-1:0]    o_members,
    input  logic                                i_fits,
    output logic                                o_busy,
    output logic                                o_result_valid,
    output mcs_pkg::t_out_word                  o_result
);
    import mcs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ROOT  = 8'b0000_0010,
        S_LROW  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_TEST  = 8'b0001_0000,
        S_JUDGE = 8'b0010_0000,
        S_PSTK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                  r_state,     n_state;
    logic [CNT_W-1:0]        r_n,         n_n;
    logic [CNT_W-1:0]        r_cand,      n_cand;
    logic [CNT_W-1:0]        r_depth,     n_depth;
    logic [IDX_W-1:0]        r_last,      n_last;
    logic [MAX_VERTICES-1:0] r_last_row,  n_last_row;
    logic [MAX_VERTICES-1:0] r_cur,       n_cur;
    logic [CNT_W-1:0]        r_best_size, n_best_size;
    logic [MAX_VERTICES-1:0] r_best,      n_best;

    logic [IDX_W-1:0]        cand_idx;
    logic [MAX_VERTICES-1:0] cand_bit;
    logic [MAX_VERTICES-1:0] last_bit;
    logic [CNT_W-1:0]        cand_inc;
    logic [CNT_W-1:0]        depth_m2;
    logic [CNT_W-1:0]        n_clamped;

    assign cand_idx  = r_cand[IDX_W-1:0];
    assign cand_bit  = MAX_VERTICES'(1) << cand_idx;
    assign last_bit  = MAX_VERTICES'(1) << r_last;
    assign cand_inc  = r_cand + CNT_W'(1);
    assign depth_m2  = r_depth - CNT_W'(2);
    assign n_clamped = (i_vertex_count > VCOUNT_W'(MAX_VERTICES)) ?
                       CNT_W'(MAX_VERTICES) : CNT_W'(i_vertex_count);

    // Next-state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cand      = r_cand;
        n_depth     = r_depth;
        n_last      = r_last;
        n_last_row  = r_last_row;
        n_cur       = r_cur;
        n_best_size = r_best_size;
        n_best      = r_best;
        o_adj_raddr = cand_idx;
        o_stk.we    = 1'b0;
        o_stk.waddr = r_depth[IDX_W-1:0];
        o_stk.wdata = cand_idx;
        o_stk.raddr = depth_m2[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_n         = n_clamped;
                    n_cand      = '0;
                    n_best_size = '0;
                    n_best      = '0;
                    n_state     = S_ROOT;
                end
            end
            // Open a new root, or finish when all roots are done
            S_ROOT: begin
                if (r_cand >= r_n) begin
                    n_state = S_DONE;
                end else begin
                    o_stk.we    = 1'b1;
                    o_stk.waddr = '0;
                    n_depth     = CNT_W'(1);
                    n_cur       = cand_bit;
                    n_last      = cand_idx;
                    n_cand      = cand_inc;
                    n_state     = S_LROW;
                end
            end
            // Top-of-path row arrives from memory
            S_LROW: begin
                n_last_row = i_adj_rdata;
                n_state    = S_SCAN;
            end
            // Skip non-neighbors of the top; fetch a neighbor's row
            S_SCAN: begin
                if (r_cand >= r_n) begin
                    n_state = S_JUDGE;
                end else if (r_last_row[cand_idx]) begin
                    n_state = S_TEST;
                end else begin
                    n_cand = cand_inc;
                end
            end
            // Candidate row in hand: push if it joins every member
            S_TEST: begin
                if (i_fits) begin
                    o_stk.we   = 1'b1;
                    n_depth    = r_depth + CNT_W'(1);
                    n_cur      = r_cur | cand_bit;
                    n_last     = cand_idx;
                    n_last_row = i_adj_rdata;
                end
                n_cand  = cand_inc;
                n_state = S_SCAN;
            end
            // Node exhausted: score it and pop
            S_JUDGE: begin
                if (r_depth > r_best_size) begin
                    n_best_size = r_depth;
                    n_best      = r_cur;
                end
                n_cur   = r_cur & ~last_bit;
                n_depth = r_depth - CNT_W'(1);
                n_cand  = CNT_W'(r_last) + CNT_W'(1);
                if (r_depth == CNT_W'(1)) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_PSTK;
                end
            end
            // New top vertex read back from the stack
            S_PSTK: begin
                n_last      = i_stk_rdata;
                o_adj_raddr = i_stk_rdata;
                n_state     = S_LROW;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_cur       <= '0;
            r_best_size <= '0;
            r_best      <= '0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_cur       <= n_cur;
            r_best_size <= n_best_size;
            r_best      <= n_best;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_cand     <= n_cand;
        r_last     <= n_last;
        r_last_row <= n_last_row;
    end

    assign o_members                = r_cur;
    assign o_busy                   = (r_state != S_IDLE);
    assign o_result_valid           = (r_state == S_DONE);
    assign o_result.max_clique_size = SIZE_W'(r_best_size);
    assign o_result.clique_members  = ROW_BITS_W'(r_best);

endmodule

FILE: hdl/max_clique_search.sv
// ----------------------------------------------------------------------------
// max_clique_search
// Maximum clique search over a stored adjacency matrix by depth-first
// backtracking with an explicit path stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken on a cycle where start is high and busy is low.
//   A load word (command 0) writes one adjacency row in that cycle; busy
//   stays low, so loads go back to back, one row per cycle, no result.
//   A start word (command 1) raises busy and runs the whole search. When
//   it ends, o_result_valid is high for exactly one cycle with the size and
//   member mask of the first largest clique found; busy drops the cycle
//   after. The receiver cannot stall; the result word is not held.
//   Search time depends on the graph: opening a root passes the root and
//   row-load states; a candidate that is not a neighbor of the top vertex
//   costs a scan step, and one whose row must be fetched also passes the
//   test state; closing a node takes the end of scan and the score, then
//   a stack read and a row read to resume its parent. After the last root,
//   and at once with zero vertices, the root state goes to done, which
//   raises the strobe. The single adjacency read port and the one shared
//   test set this; it grows exponentially with the clique structure.
//   The vertex count register sits on its own channel (always ready) and
//   resets to 64; write it only while busy is low. Reset is synchronous and
//   returns the block to idle; adjacency rows must be loaded before use.
// ----------------------------------------------------------------------------
module max_clique_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mcs_pkg::t_in_word               i_item,
    output logic                            o_result_valid,
    output mcs_pkg::t_out_word              o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mcs_pkg::VCOUNT_W-1:0]    i_cfg_data
);
    import mcs_pkg::*;

    logic [VCOUNT_W-1:0]     r_vertex_count;
    logic                    seq_busy;
    logic                    accept;
    logic                    load_we;
    logic                    go;
    logic [IDX_W-1:0]        adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    t_stk_port               stk;
    logic [IDX_W-1:0]        stk_rdata;
    logic [MAX_VERTICES-1:0] members;
    logic                    fits;

    // Input word decode
    assign accept  = start && !seq_busy;
    assign load_we = accept && (i_item.command == CMD_LOAD) &&
                     (int'(i_item.row_index) < MAX_VERTICES);
    assign go      = accept && (i_item.command == CMD_START);
    assign busy    = seq_busy;

    // Vertex count register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    mcs_adj_mem u_adj_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_item.row_index[IDX_W-1:0]),
        .i_wdata (i_item.row_bits[MAX_VERTICES-1:0]),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    mcs_stack_mem u_stack_mem (
        .i_clk   (i_clk),
        .i_port  (stk),
        .o_rdata (stk_rdata)
    );

    mcs_ext_unit u_ext_unit (
        .i_row     (adj_rdata),
        .i_members (members),
        .o_fits    (fits)
    );

    mcs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_vertex_count (r_vertex_count),
        .o_adj_raddr    (adj_raddr),
        .i_adj_rdata    (adj_rdata),
        .o_stk          (stk),
        .i_stk_rdata    (stk_rdata),
        .o_members      (members),
        .i_fits         (fits),
        .o_busy         (seq_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
